// ----- hdl/lzbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ back-reference decompressor package
// Field widths, token decoding constants and the check result type shared
// by the channel interfaces and the core modules.
// ----------------------------------------------------------------------------
package lzbd_pkg;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 16;
   localparam int COUNT_W = 32;
   localparam int LEN_W = 5;
   localparam int DIST_W = 13;
   localparam int PTR_CALC_W = DIST_W + 1;

   localparam logic [CODE_W-1:0] LEN_MASK = 16'hF000;
   localparam logic [CODE_W-1:0] DIST_MASK = 16'h0FFF;
   localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;
   localparam logic [DIST_W-1:0] DIST_BIAS = 13'd1;
   localparam logic [COUNT_W-1:0] OUTPUT_LENGTH_RESET = 32'd1;

   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_BACKREF = 1'b1;

   typedef struct packed {
      logic dist_err;
      logic len_err;
      logic end_hit;
   } chk_type;

endpackage
`default_nettype wire

// ----- hdl/lzbd_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one compressed token per beat.
// ----------------------------------------------------------------------------
interface lzbd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [lzbd_pkg::BYTE_W-1:0]   literal_byte;
   logic [lzbd_pkg::CODE_W-1:0]   ref_code;

   modport source (output valid, req_type, literal_byte, ref_code, input ready);
   modport sink (input valid, req_type, literal_byte, ref_code, output ready);
endinterface
`default_nettype wire

// ----- hdl/lzbd_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decompressed byte and its flags per beat.
// ----------------------------------------------------------------------------
interface lzbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lzbd_pkg::BYTE_W-1:0]   out_byte;
   logic                          run_last;
   logic                          block_done;
   logic                          error;

   modport source (output valid, out_byte, run_last, block_done, error, input ready);
   modport sink (input valid, out_byte, run_last, block_done, error, output ready);
endinterface
`default_nettype wire

// ----- hdl/lzbd_csr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the output length register write data.
// ----------------------------------------------------------------------------
interface lzbd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lzbd_pkg::COUNT_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/lz_backref_decompressor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ back-reference decompressor core
// Expands literal and back-reference tokens into bytes through a history
// ring at one byte per unstalled emit cycle, with distance and length checks.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_bus   in         one token: req_type, literal_byte, ref_code
//  rsp_bus   out        one byte: out_byte, run_last, block_done, error
//  csr_bus   in         output_length write data
//
// A literal passes through the check and emit states; a back reference adds
// a prepare state that issues the first history read before its bytes are
// emitted, set by the single read and write port and registered read of the RAM.
// A stalled result beat holds the copy in place; no token is taken meanwhile.
// Reset clears the counters and state; the history holds no reset value and
// needs no clearing pass. After the block ends, tokens are taken and dropped.
// ----------------------------------------------------------------------------
module lz_backref_decompressor_core #(
   parameter int WINDOW_SIZE = 4096
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lzbd_req_if.sink   req_bus,
   lzbd_rsp_if.source rsp_bus,
   lzbd_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(WINDOW_SIZE);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_PREP  = 6'b000100,
      S_EMIT  = 6'b001000,
      S_ERR   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [lzbd_pkg::COUNT_W-1:0]      written_ff, written_in;
   logic [lzbd_pkg::COUNT_W-1:0]      olen_ff, olen_in;
   logic [AW-1:0]                     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]                     src_ff, src_in;
   logic [lzbd_pkg::LEN_W-1:0]        cnt_ff, cnt_in;
   logic                              first_ff, first_in;
   logic                              dist1_ff, dist1_in;
   logic                              end_ff, end_in;
   logic                              kind_ff, kind_in;
   logic [lzbd_pkg::BYTE_W-1:0]       lit_ff, lit_in;
   logic [lzbd_pkg::CODE_W-1:0]       code_ff, code_in;
   logic [lzbd_pkg::BYTE_W-1:0]       prev_ff, prev_in;

   lzbd_pkg::chk_type                 chk;
   logic [lzbd_pkg::LEN_W-1:0]        len;
   logic                              dist_one;
   logic [AW-1:0]                     src_start;
   logic [AW-1:0]                     src_next;
   logic [AW-1:0]                     wr_ptr_next;
   logic [lzbd_pkg::BYTE_W-1:0]       rd_data;
   logic [lzbd_pkg::BYTE_W-1:0]       emit_byte;
   logic                              rsp_fire;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;

   lzbd_check #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_check (
      .kind         (kind_ff),
      .code         (code_ff),
      .written      (written_ff),
      .output_length(olen_ff),
      .wr_ptr       (wr_ptr_ff),
      .chk          (chk),
      .len          (len),
      .dist_one     (dist_one),
      .src_start    (src_start)
   );

   lzbd_ram #(
      .WIDTH(lzbd_pkg::BYTE_W),
      .DEPTH(WINDOW_SIZE)
   ) u_history (
      .clock  (clock),
      .wr_en  (rsp_fire && (state_ff == S_EMIT)),
      .wr_addr(wr_ptr_ff),
      .wr_data(emit_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      src_next = (src_ff == AW'(WINDOW_SIZE - 1)) ? '0 : src_ff + 1'b1;
      wr_ptr_next = (wr_ptr_ff == AW'(WINDOW_SIZE - 1)) ? '0 : wr_ptr_ff + 1'b1;

      if (kind_ff == lzbd_pkg::KIND_LITERAL) begin
         emit_byte = lit_ff;
      end else if (dist1_ff && !first_ff) begin
         emit_byte = prev_ff;
      end else begin
         emit_byte = rd_data;
      end

      req_bus.ready = (state_ff == S_IDLE) || (state_ff == S_DONE);
      csr_bus.ready = 1'b1;

      rsp_bus.valid = (state_ff == S_EMIT) || (state_ff == S_ERR);
      rsp_bus.out_byte = (state_ff == S_EMIT) ? emit_byte : '0;
      rsp_bus.run_last = (state_ff == S_ERR) || (cnt_ff == '0);
      rsp_bus.block_done = (state_ff == S_ERR) || ((cnt_ff == '0) && end_ff);
      rsp_bus.error = (state_ff == S_ERR);
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
   end

   always_comb begin
      state_in = state_ff;
      written_in = written_ff;
      olen_in = olen_ff;
      wr_ptr_in = wr_ptr_ff;
      src_in = src_ff;
      cnt_in = cnt_ff;
      first_in = first_ff;
      dist1_in = dist1_ff;
      end_in = end_ff;
      kind_in = kind_ff;
      lit_in = lit_ff;
      code_in = code_ff;
      prev_in = prev_ff;
      rd_en = 1'b0;
      rd_addr = src_ff;

      if (csr_bus.valid) begin
         olen_in = csr_bus.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               kind_in = req_bus.req_type;
               lit_in = req_bus.literal_byte;
               code_in = req_bus.ref_code;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            end_in = chk.end_hit;
            dist1_in = dist_one;
            first_in = 1'b1;
            if (chk.dist_err || chk.len_err) begin
               state_in = S_ERR;
            end else if (kind_ff == lzbd_pkg::KIND_LITERAL) begin
               cnt_in = '0;
               state_in = S_EMIT;
            end else begin
               cnt_in = len - 1'b1;
               src_in = src_start;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            rd_en = 1'b1;
            rd_addr = src_ff;
            src_in = src_next;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_fire) begin
               rd_en = 1'b1;
               rd_addr = src_ff;
               src_in = src_next;
               prev_in = emit_byte;
               first_in = 1'b0;
               wr_ptr_in = wr_ptr_next;
               written_in = written_ff + 1'b1;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = end_ff ? S_DONE : S_IDLE;
               end
            end
         end
         S_ERR: begin
            if (rsp_fire) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_DONE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         written_ff <= '0;
         olen_ff <= lzbd_pkg::OUTPUT_LENGTH_RESET;
         wr_ptr_ff <= '0;
         cnt_ff <= '0;
         first_ff <= 1'b1;
         dist1_ff <= 1'b0;
         end_ff <= 1'b0;
         kind_ff <= lzbd_pkg::KIND_LITERAL;
      end else begin
         state_ff <= state_in;
         written_ff <= written_in;
         olen_ff <= olen_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff <= cnt_in;
         first_ff <= first_in;
         dist1_ff <= dist1_in;
         end_ff <= end_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      lit_ff <= lit_in;
      code_ff <= code_in;
      prev_ff <= prev_in;
   end

endmodule
`default_nettype wire

// ----- hdl/lzbd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module lzbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/lzbd_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token check unit
// Decodes a token, checks its distance and length against the bytes written
// and the output length, and computes the first copy source address.
// ----------------------------------------------------------------------------
module lzbd_check #(
   parameter int WINDOW_SIZE = 4096
) (
   input  wire logic                              kind,
   input  wire logic [lzbd_pkg::CODE_W-1:0]       code,
   input  wire logic [lzbd_pkg::COUNT_W-1:0]      written,
   input  wire logic [lzbd_pkg::COUNT_W-1:0]      output_length,
   input  wire logic [$clog2(WINDOW_SIZE)-1:0]    wr_ptr,
   output lzbd_pkg::chk_type                      chk,
   output logic      [lzbd_pkg::LEN_W-1:0]        len,
   output logic                                   dist_one,
   output logic      [$clog2(WINDOW_SIZE)-1:0]    src_start
);

   localparam int AW = $clog2(WINDOW_SIZE);

   logic [lzbd_pkg::DIST_W-1:0]     distance;
   logic [lzbd_pkg::LEN_W-1:0]      len_eff;
   logic [lzbd_pkg::COUNT_W:0]      sum;
   logic [lzbd_pkg::COUNT_W:0]      limit;
   logic [lzbd_pkg::PTR_CALC_W-1:0] diff;
   logic [lzbd_pkg::PTR_CALC_W-1:0] wrapped;

   always_comb begin
      len = lzbd_pkg::LEN_W'((code & lzbd_pkg::LEN_MASK) >> 12) + lzbd_pkg::LEN_BIAS;
      distance = lzbd_pkg::DIST_W'(code & lzbd_pkg::DIST_MASK) + lzbd_pkg::DIST_BIAS;
      dist_one = (distance == lzbd_pkg::DIST_BIAS);
      len_eff = (kind == lzbd_pkg::KIND_BACKREF) ? len : lzbd_pkg::LEN_W'(1);

      sum = {1'b0, written} + (lzbd_pkg::COUNT_W + 1)'(len_eff);
      limit = {1'b0, output_length};
      chk.len_err = (sum > limit);
      chk.end_hit = (sum == limit);
      chk.dist_err = (kind == lzbd_pkg::KIND_BACKREF)
                     && ((lzbd_pkg::COUNT_W'(distance) > written)
                         || (distance > lzbd_pkg::DIST_W'(WINDOW_SIZE)));

      diff = lzbd_pkg::PTR_CALC_W'(wr_ptr) - lzbd_pkg::PTR_CALC_W'(distance);
      wrapped = diff[lzbd_pkg::PTR_CALC_W-1]
                ? diff + lzbd_pkg::PTR_CALC_W'(WINDOW_SIZE) : diff;
      src_start = wrapped[AW-1:0];
   end

endmodule
`default_nettype wire
